// ===== design/sdo_pkg.sv =====
// Shared types, constants and helpers of the SDO expedited server.
`default_nettype none
package sdo_pkg;

  localparam logic [10:0] REQ_BASE = 11'h600;
  localparam logic [10:0] RSP_BASE = 11'h580;

  localparam logic [2:0] CS_WRITE = 3'd1;
  localparam logic [2:0] CS_READ  = 3'd2;

  localparam logic [7:0] ACK_CMD   = 8'h60;
  localparam logic [7:0] ABORT_CMD = 8'h80;
  localparam logic [7:0] READ_CMD  = 8'h43;

  localparam logic [31:0] ABT_NO_OBJECT   = 32'h0602_0000;
  localparam logic [31:0] ABT_READ_ONLY   = 32'h0601_0002;
  localparam logic [31:0] ABT_WRITE_ONLY  = 32'h0601_0001;
  localparam logic [31:0] ABT_LEN_MISMATCH = 32'h0607_0010;
  localparam logic [31:0] ABT_UNSUPPORTED = 32'h0601_0000;

  localparam logic [2:0] MAX_LEN = 3'd4;

  typedef struct packed {
    logic [15:0] index;
    logic [7:0]  subindex;
    logic [1:0]  access;
    logic [2:0]  length;
    logic [31:0] value;
  } entry_t;

  typedef struct packed {
    logic [31:0] tx_data_low;
    logic [31:0] tx_data_high;
    logic        is_abort;
    logic        changed;
    logic [3:0]  changed_slot;
  } rsp_t;

  // Mask of the low len bytes; four or more selects the whole word.
  function automatic logic [31:0] byte_mask(input logic [2:0] len);
    logic [31:0] m;
    case (len)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== design/sdo_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module sdo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/sdo_ctrl.sv =====
// Request sequencer: decode, slot search over the dictionary RAM, checks and update.
`default_nettype none
module sdo_ctrl
  import sdo_pkg::*;
#(
  parameter int NUM_SLOTS = 16,
  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [6:0]    node_id,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          in_command,
  input  wire logic [10:0]   in_can_id,
  input  wire logic [31:0]   in_data_low,
  input  wire logic [31:0]   in_data_high,
  input  wire logic [3:0]    in_slot,
  input  wire logic [15:0]   in_entry_index,
  input  wire logic [7:0]    in_entry_subindex,
  input  wire logic [1:0]    in_entry_access,
  input  wire logic [2:0]    in_entry_length,
  input  wire logic [31:0]   in_entry_value,
  output logic               rsp_valid,
  output rsp_t               rsp,
  input  wire logic          rsp_take,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output entry_t             ram_wdata,
  output logic [AW-1:0]      ram_raddr,
  input  wire entry_t        ram_rdata
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_CHECK  = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  localparam logic [AW-1:0] LAST = AW'(NUM_SLOTS - 1);

  logic [1:0]           state_r, state_nxt;
  logic [AW-1:0]        scan_r, scan_nxt;
  logic                 pend_r, pend_nxt;
  logic [AW-1:0]        pend_addr_r, pend_addr_nxt;
  logic [31:0]          lo_r, lo_nxt;
  logic [31:0]          hi_r, hi_nxt;
  logic                 is_wr_r, is_wr_nxt;
  logic                 hit_r, hit_nxt;
  logic [AW-1:0]        hit_slot_r, hit_slot_nxt;
  entry_t               hit_ent_r, hit_ent_nxt;
  rsp_t                 rsp_r, rsp_nxt;
  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;

  logic        in_acc;
  logic        id_match;
  logic [2:0]  cs;
  logic [2:0]  ld_len;
  logic        pend_match;
  logic [2:0]  wr_size;
  logic [31:0] wr_mask;
  logic [2:0]  rd_fill;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign id_match   = (in_can_id == (REQ_BASE + {4'b0, node_id}));
  assign cs         = in_data_low[7:5];
  assign ld_len     = (in_entry_length > MAX_LEN) ? MAX_LEN : in_entry_length;
  assign pend_match = pend_r && valid_r[pend_addr_r] &&
                      (ram_rdata.index == lo_r[23:8]) &&
                      (ram_rdata.subindex == lo_r[31:24]);
  assign wr_size    = MAX_LEN - {1'b0, lo_r[3:2]};
  assign wr_mask    = byte_mask(wr_size);
  assign rd_fill    = MAX_LEN - hit_ent_r.length;

  assign ram_raddr = scan_r;
  assign rsp_valid = (state_r == ST_EMIT);
  assign rsp       = rsp_r;

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = scan_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    is_wr_nxt     = is_wr_r;
    hit_nxt       = hit_r;
    hit_slot_nxt  = hit_slot_r;
    hit_ent_nxt   = hit_ent_r;
    rsp_nxt       = rsp_r;
    valid_nxt     = valid_r;
    ram_we        = 1'b0;
    ram_waddr     = AW'(in_slot);
    ram_wdata.index    = in_entry_index;
    ram_wdata.subindex = in_entry_subindex;
    ram_wdata.access   = in_entry_access;
    ram_wdata.length   = ld_len;
    ram_wdata.value    = in_entry_value & byte_mask(ld_len);

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          lo_nxt    = in_data_low;
          hi_nxt    = in_data_high;
          is_wr_nxt = (cs == CS_WRITE);
          scan_nxt  = '0;
          if (in_command) begin
            // load: define the slot, no response
            if (int'(in_slot) < NUM_SLOTS) begin
              ram_we = 1'b1;
              valid_nxt[AW'(in_slot)] = (ld_len != 3'd0);
            end
          end else if (id_match) begin
            if (cs == CS_WRITE || cs == CS_READ) begin
              state_nxt = ST_SEARCH;
            end else begin
              rsp_nxt.tx_data_low  = {in_data_low[31:8], ABORT_CMD};
              rsp_nxt.tx_data_high = ABT_UNSUPPORTED;
              rsp_nxt.is_abort     = 1'b1;
              rsp_nxt.changed      = 1'b0;
              rsp_nxt.changed_slot = 4'd0;
              state_nxt            = ST_EMIT;
            end
          end
        end
      end

      ST_SEARCH: begin
        // one read issued and one compared per cycle; lowest slot wins
        pend_nxt      = 1'b1;
        pend_addr_nxt = scan_r;
        if (scan_r != LAST) begin
          scan_nxt = scan_r + AW'(1);
        end
        if (pend_match) begin
          hit_nxt      = 1'b1;
          hit_slot_nxt = pend_addr_r;
          hit_ent_nxt  = ram_rdata;
          pend_nxt     = 1'b0;
          state_nxt    = ST_CHECK;
        end else if (pend_r && pend_addr_r == LAST) begin
          hit_nxt   = 1'b0;
          pend_nxt  = 1'b0;
          state_nxt = ST_CHECK;
        end
      end

      ST_CHECK: begin
        rsp_nxt.tx_data_low  = {lo_r[31:8], ABORT_CMD};
        rsp_nxt.is_abort     = 1'b1;
        rsp_nxt.changed      = 1'b0;
        rsp_nxt.changed_slot = 4'd0;
        ram_waddr            = hit_slot_r;
        ram_wdata            = hit_ent_r;
        ram_wdata.value      = (hit_ent_r.value & ~wr_mask) | (hi_r & wr_mask);
        if (!hit_r) begin
          rsp_nxt.tx_data_high = ABT_NO_OBJECT;
        end else if (is_wr_r) begin
          if (!hit_ent_r.access[1]) begin
            rsp_nxt.tx_data_high = ABT_READ_ONLY;
          end else if (wr_size > hit_ent_r.length) begin
            rsp_nxt.tx_data_high = ABT_LEN_MISMATCH;
          end else begin
            ram_we                 = 1'b1;
            rsp_nxt.tx_data_low    = {lo_r[31:8], ACK_CMD};
            rsp_nxt.tx_data_high   = 32'd0;
            rsp_nxt.is_abort       = 1'b0;
            rsp_nxt.changed        = 1'b1;
            rsp_nxt.changed_slot   = 4'(hit_slot_r);
          end
        end else begin
          if (!hit_ent_r.access[0]) begin
            rsp_nxt.tx_data_high = ABT_WRITE_ONLY;
          end else begin
            rsp_nxt.tx_data_low  = {lo_r[31:8], READ_CMD | {4'b0, rd_fill[1:0], 2'b0}};
            rsp_nxt.tx_data_high = hit_ent_r.value & byte_mask(hit_ent_r.length);
            rsp_nxt.is_abort     = 1'b0;
          end
        end
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (rsp_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      valid_r <= valid_nxt;
    end
    scan_r      <= scan_nxt;
    pend_addr_r <= pend_addr_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    is_wr_r     <= is_wr_nxt;
    hit_r       <= hit_nxt;
    hit_slot_r  <= hit_slot_nxt;
    hit_ent_r   <= hit_ent_nxt;
    rsp_r       <= rsp_nxt;
  end

endmodule
`default_nettype wire

// ===== design/sdo_expedited_server.sv =====
// Top level: node id register, output register, sequencer and dictionary RAM.
// A served request scans the dictionary RAM from slot 0 until the object is
// found or the last slot has been compared, then loads the output register
// (the slot scan reads one RAM entry per cycle). A load writes its slot in
// the cycle it is accepted. One request at a time; input stalls until done.
// Reset sets node id to 1, clears all slot valid bits, sequencer state and out_valid.
`default_nettype none
module sdo_expedited_server
  import sdo_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [10:0] in_can_id,
  input  wire logic [31:0] in_data_low,
  input  wire logic [31:0] in_data_high,
  input  wire logic [3:0]  in_slot,
  input  wire logic [15:0] in_entry_index,
  input  wire logic [7:0]  in_entry_subindex,
  input  wire logic [1:0]  in_entry_access,
  input  wire logic [2:0]  in_entry_length,
  input  wire logic [31:0] in_entry_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [10:0]      out_tx_can_id,
  output logic [31:0]      out_tx_data_low,
  output logic [31:0]      out_tx_data_high,
  output logic             out_is_abort,
  output logic             out_changed,
  output logic [3:0]       out_changed_slot
);

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [6:0]  node_id_r, node_id_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [10:0] out_can_id_r, out_can_id_nxt;
  rsp_t        out_rsp_r, out_rsp_nxt;

  logic          rsp_valid;
  rsp_t          rsp;
  logic          rsp_take;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;

  assign rsp_take = rsp_valid && (!out_valid_r || !out_stall);

  sdo_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .node_id           (node_id_r),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_can_id         (in_can_id),
    .in_data_low       (in_data_low),
    .in_data_high      (in_data_high),
    .in_slot           (in_slot),
    .in_entry_index    (in_entry_index),
    .in_entry_subindex (in_entry_subindex),
    .in_entry_access   (in_entry_access),
    .in_entry_length   (in_entry_length),
    .in_entry_value    (in_entry_value),
    .rsp_valid         (rsp_valid),
    .rsp               (rsp),
    .rsp_take          (rsp_take),
    .ram_we            (ram_we),
    .ram_waddr         (ram_waddr),
    .ram_wdata         (ram_wdata),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata)
  );

  sdo_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_SLOTS)
  ) u_dict_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    node_id_nxt    = cfg_wr_en ? cfg_wr_data : node_id_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_can_id_nxt = out_can_id_r;
    out_rsp_nxt    = out_rsp_r;
    if (rsp_take) begin
      out_valid_nxt  = 1'b1;
      out_can_id_nxt = RSP_BASE + {4'b0, node_id_r};
      out_rsp_nxt    = rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r   <= 7'd1;
      out_valid_r <= 1'b0;
    end else begin
      node_id_r   <= node_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_can_id_r <= out_can_id_nxt;
    out_rsp_r    <= out_rsp_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_tx_can_id    = out_can_id_r;
  assign out_tx_data_low  = out_rsp_r.tx_data_low;
  assign out_tx_data_high = out_rsp_r.tx_data_high;
  assign out_is_abort     = out_rsp_r.is_abort;
  assign out_changed      = out_rsp_r.changed;
  assign out_changed_slot = out_rsp_r.changed_slot;

  a_no_out_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("response valid right after reset");

  a_abort_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_abort |-> out_tx_data_low[7:0] == ABORT_CMD &&
      !out_changed)
    else $error("abort frame with wrong command or changed flag");

  a_rsp_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !cfg_wr_en |-> out_tx_can_id == RSP_BASE + {4'b0, node_id_r})
    else $error("response identifier does not follow node id");

  a_busy_on_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_valid |-> in_stall)
    else $error("sequencer accepts while a response is pending");

endmodule
`default_nettype wire
